FILE: hdl/mpef_pkg.sv
// ----------------------------------------------------------------------------
// mpef_pkg
// Shared types, constants and the exp table builder for the Morse pair block.
// ----------------------------------------------------------------------------
package mpef_pkg;

	localparam int FRAC_BITS = 20;
	localparam int EXP_LAT = 10;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] Q30_ONE = 31'd1 << 30;
	localparam logic [42:0] EXP_LIMIT = 43'd16 << FRAC_BITS;
	localparam logic [53:0] MAG_CAP = 54'd1 << 50;

	typedef enum logic [2:0] {
		CFG_DEPTH  = 3'd0,
		CFG_WIDTH  = 3'd1,
		CFG_R0     = 3'd2,
		CFG_ESHIFT = 3'd3,
		CFG_FSHIFT = 3'd4,
		CFG_CUTOFF = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [30:0] depth;
		logic [30:0] width;
		logic [30:0] r0;
		logic [31:0] eshift;
		logic [31:0] fshift;
		logic [30:0] cutoff;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        big;
		logic        tiny;
		logic [24:0] y;
	} exp_arg_t;

	typedef struct packed {
		logic        valid;
		logic        ovf;
		logic [30:0] e;
	} exp_res_t;

	// 2^(j/2^bits) in Q.30 by a truncated series, evaluated at elaboration
	function automatic logic [30:0] exp_frac_entry(input int unsigned j, input int unsigned bits);
		logic [63:0] z;
		logic [63:0] term;
		logic [63:0] sum;
		z = (64'(j) * 64'(LN2_Q30)) >> bits;
		term = 64'd1 << 30;
		sum = term;
		for (int n = 1; n <= 24; n++) begin
			term = ((term * z) >> 30) / 64'(n);
			sum = sum + term;
		end
		return sum[30:0];
	endfunction

endpackage

FILE: hdl/morse_pair_energy_force.sv
// ----------------------------------------------------------------------------
// morse_pair_energy_force
// Shifted-force Morse pair energy and force from one pair distance, Q12.20.
// ----------------------------------------------------------------------------
// an accepted start reaches the done strobe through s1 to s3, the exp pipeline and s4 to s9
// throughput: one pair per cycle, set by the fully pipelined exp and multipliers
// busy stays low; done is a single-cycle strobe that the receiver cannot stall
// reset clears all configuration registers and every stage valid bit
module morse_pair_energy_force #(
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [30:0]        pair_distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] pair_energy,
	output logic signed [31:0] pair_force,
	output logic               overflow
);

	localparam int RB = mpef_pkg::FRAC_BITS - 1;
	localparam int LAT = mpef_pkg::EXP_LAT;
	localparam logic signed [55:0] S32_MAX = 56'sd2147483647;
	localparam logic signed [55:0] S32_MIN = -56'sd2147483648;

	mpef_pkg::cfg_t cfg;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	mpef_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// D*a only changes with configuration
	logic [61:0] t1p_q;
	logic [41:0] t1_q;
	logic [62:0] t1r;
	assign t1r = (63'(t1p_q) + (63'd1 << RB)) >> mpef_pkg::FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1p_q <= '0;
			t1_q  <= '0;
		end else begin
			t1p_q <= 62'(cfg.depth) * 62'(cfg.width);
			t1_q  <= t1r[41:0];
		end
	end

	logic v_s1, v_s2, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	mpef_pkg::exp_res_t exp_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s4 <= exp_res.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// s1: distance differences
	logic signed [31:0] d_s1, rcr_s1;

	always_ff @(posedge clk) begin
		d_s1   <= $signed({1'b0, pair_distance}) - $signed({1'b0, cfg.r0});
		rcr_s1 <= $signed({1'b0, cfg.cutoff}) - $signed({1'b0, pair_distance});
	end

	// s2: a*(r-r0) and Fc*(rc-r) as magnitudes
	logic [31:0] dabs, rabs, fcabs;
	logic [61:0] ya_s2;
	logic [62:0] fp_s2;
	logic        dneg_s2, fneg_s2;
	assign dabs = d_s1[31] ? 32'(-d_s1) : 32'(d_s1);
	assign rabs = rcr_s1[31] ? 32'(-rcr_s1) : 32'(rcr_s1);
	assign fcabs = cfg.fshift[31] ? (32'd0 - cfg.fshift) : cfg.fshift;

	always_ff @(posedge clk) begin
		ya_s2   <= 62'(cfg.width) * 62'(dabs[30:0]);
		dneg_s2 <= d_s1[31];
		fp_s2   <= 63'(fcabs) * 63'(rabs[30:0]);
		fneg_s2 <= cfg.fshift[31] ^ rcr_s1[31];
	end

	// s3: round, negate, range-check the exp argument
	logic [62:0]        ymag_w;
	logic [63:0]        fmag_w;
	logic [42:0]        ymag, fmag;
	logic signed [24:0] y25;
	logic signed [43:0] f1_w, f1_s3;
	logic               ylarge;
	mpef_pkg::exp_arg_t arg_s3;
	assign ymag_w = (63'(ya_s2) + (63'd1 << RB)) >> mpef_pkg::FRAC_BITS;
	assign ymag = ymag_w[42:0];
	assign fmag_w = (64'(fp_s2) + (64'd1 << RB)) >> mpef_pkg::FRAC_BITS;
	assign fmag = fmag_w[42:0];
	assign ylarge = ymag >= mpef_pkg::EXP_LIMIT;
	assign y25 = dneg_s2 ? $signed(ymag[24:0]) : -$signed(ymag[24:0]);
	assign f1_w = fneg_s2 ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_s3 <= '0;
		end else begin
			arg_s3.valid <= v_s2;
			arg_s3.big   <= dneg_s2 & ylarge;
			arg_s3.tiny  <= ~dneg_s2 & ylarge;
			arg_s3.y     <= y25;
		end
	end

	always_ff @(posedge clk) begin
		f1_s3 <= f1_w;
	end

	mpef_exp #(
		.TAB_BITS (EXP_TABLE_BITS)
	) u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.arg    (arg_s3),
		.res    (exp_res)
	);

	// Fc*(rc-r) rides alongside the exp pipeline
	logic signed [43:0] f1_line_q [LAT];

	always_ff @(posedge clk) begin
		f1_line_q[0] <= f1_s3;
		for (int i = 1; i < LAT; i++) begin
			f1_line_q[i] <= f1_line_q[i-1];
		end
	end

	// s4: 1-e, its square and e*(1-e)
	logic signed [32:0] om;
	logic [32:0]        omabs;
	logic [61:0]        om2p_s4, t2p_s4;
	logic               t2neg_s4, ovf_s4;
	logic signed [43:0] f1_s4;
	assign om = $signed(33'd1 << mpef_pkg::FRAC_BITS) - $signed({2'b0, exp_res.e});
	assign omabs = om[32] ? 33'(-om) : 33'(om);

	always_ff @(posedge clk) begin
		om2p_s4  <= 62'(omabs[30:0]) * 62'(omabs[30:0]);
		t2p_s4   <= 62'(exp_res.e) * 62'(omabs[30:0]);
		t2neg_s4 <= om[32];
		ovf_s4   <= exp_res.ovf;
		f1_s4    <= f1_line_q[LAT-1];
	end

	// s5: round the two products
	logic [62:0]        om2r, t2r;
	logic [41:0]        om2_s5, t2m_s5;
	logic               t2neg_s5, ovf_s5;
	logic signed [43:0] f1_s5;
	assign om2r = (63'(om2p_s4) + (63'd1 << RB)) >> mpef_pkg::FRAC_BITS;
	assign t2r = (63'(t2p_s4) + (63'd1 << RB)) >> mpef_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		om2_s5   <= om2r[41:0];
		t2m_s5   <= t2r[41:0];
		t2neg_s5 <= t2neg_s4;
		ovf_s5   <= ovf_s4;
		f1_s5    <= f1_s4;
	end

	// s6: wide products split into partial products
	logic [51:0]        pe_lo_s6, pe_hi_s6;
	logic [41:0]        m_ll_s6, m_lh_s6, m_hl_s6, m_hh_s6;
	logic               t2neg_s6, ovf_s6;
	logic signed [43:0] f1_s6;

	always_ff @(posedge clk) begin
		pe_lo_s6 <= 52'(cfg.depth) * 52'(om2_s5[20:0]);
		pe_hi_s6 <= 52'(cfg.depth) * 52'(om2_s5[41:21]);
		m_ll_s6  <= 42'(t1_q[20:0]) * 42'(t2m_s5[20:0]);
		m_lh_s6  <= 42'(t1_q[20:0]) * 42'(t2m_s5[41:21]);
		m_hl_s6  <= 42'(t1_q[41:21]) * 42'(t2m_s5[20:0]);
		m_hh_s6  <= 42'(t1_q[41:21]) * 42'(t2m_s5[41:21]);
		t2neg_s6 <= t2neg_s5;
		ovf_s6   <= ovf_s5;
		f1_s6    <= f1_s5;
	end

	// s7: recombine partial products
	logic [72:0]        ep_s7;
	logic [83:0]        mp_s7;
	logic               t2neg_s7, ovf_s7;
	logic signed [43:0] f1_s7;

	always_ff @(posedge clk) begin
		ep_s7    <= 73'(pe_lo_s6) + (73'(pe_hi_s6) << 21);
		mp_s7    <= 84'(m_ll_s6) + ((84'(m_lh_s6) + 84'(m_hl_s6)) << 21)
			+ (84'(m_hh_s6) << 42);
		t2neg_s7 <= t2neg_s6;
		ovf_s7   <= ovf_s6;
		f1_s7    <= f1_s6;
	end

	// s8: round and cap the magnitudes
	logic [73:0]        er;
	logic [84:0]        mr;
	logic [50:0]        e1_s8, mmag_s8;
	logic               mneg_s8, ovf_s8;
	logic signed [43:0] f1_s8;
	assign er = (74'(ep_s7) + (74'd1 << RB)) >> mpef_pkg::FRAC_BITS;
	assign mr = (85'(mp_s7) + (85'd1 << RB)) >> mpef_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		e1_s8   <= (er > 74'(mpef_pkg::MAG_CAP)) ? mpef_pkg::MAG_CAP[50:0] : er[50:0];
		mmag_s8 <= (mr > 85'(mpef_pkg::MAG_CAP)) ? mpef_pkg::MAG_CAP[50:0] : mr[50:0];
		mneg_s8 <= t2neg_s7;
		ovf_s8  <= ovf_s7;
		f1_s8   <= f1_s7;
	end

	// s9: final sums and saturation
	logic signed [55:0] e1_x, ec_x, fc_x, f1_x, m2_x, en_w, fo_w;
	logic signed [31:0] en_sat, fo_sat;
	logic               en_ovf, fo_ovf;
	logic signed [31:0] en_s9, fo_s9;
	logic               ovf_s9;
	assign e1_x = $signed({5'b0, e1_s8});
	assign ec_x = $signed({{24{cfg.eshift[31]}}, cfg.eshift});
	assign fc_x = $signed({{24{cfg.fshift[31]}}, cfg.fshift});
	assign f1_x = $signed({{12{f1_s8[43]}}, f1_s8});
	assign m2_x = $signed({4'b0, mmag_s8, 1'b0});
	assign en_w = e1_x - ec_x - f1_x;
	assign fo_w = mneg_s8 ? (m2_x - fc_x) : (-m2_x - fc_x);

	always_comb begin
		en_ovf = 1'b1;
		fo_ovf = 1'b1;
		if (en_w > S32_MAX) begin
			en_sat = 32'sh7FFFFFFF;
		end else if (en_w < S32_MIN) begin
			en_sat = 32'sh80000000;
		end else begin
			en_sat = en_w[31:0];
			en_ovf = 1'b0;
		end
		if (fo_w > S32_MAX) begin
			fo_sat = 32'sh7FFFFFFF;
		end else if (fo_w < S32_MIN) begin
			fo_sat = 32'sh80000000;
		end else begin
			fo_sat = fo_w[31:0];
			fo_ovf = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		en_s9  <= en_sat;
		fo_s9  <= fo_sat;
		ovf_s9 <= ovf_s8 | en_ovf | fo_ovf;
	end

	assign done = v_s9;
	assign pair_energy = en_s9;
	assign pair_force = fo_s9;
	assign overflow = ovf_s9;

endmodule

FILE: hdl/mpef_cfg.sv
// ----------------------------------------------------------------------------
// mpef_cfg
// Configuration register file, written one beat at a time.
// ----------------------------------------------------------------------------
module mpef_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output mpef_pkg::cfg_t    cfg
);

	mpef_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (mpef_pkg::cfg_index_t'(cfg_index))
				mpef_pkg::CFG_DEPTH:  cfg_q.depth  <= cfg_data[30:0];
				mpef_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data[30:0];
				mpef_pkg::CFG_R0:     cfg_q.r0     <= cfg_data[30:0];
				mpef_pkg::CFG_ESHIFT: cfg_q.eshift <= cfg_data;
				mpef_pkg::CFG_FSHIFT: cfg_q.fshift <= cfg_data;
				mpef_pkg::CFG_CUTOFF: cfg_q.cutoff <= cfg_data[30:0];
				default:              cfg_q        <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/mpef_exp.sv
// ----------------------------------------------------------------------------
// mpef_exp
// Pipelined exp of a Q5.20 argument: ln2 range reduction, table, cubic.
// ----------------------------------------------------------------------------
module mpef_exp #(
	parameter int TAB_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpef_pkg::exp_arg_t   arg,
	output mpef_pkg::exp_res_t   res
);

	localparam int TAB_SIZE = 1 << TAB_BITS;
	localparam int QW = TAB_BITS + 6;
	localparam int RW = TAB_BITS + 11;
	localparam int PW = RW + 26;
	localparam int XW = TAB_BITS + 38;
	localparam int LINE = mpef_pkg::EXP_LAT - 1;
	localparam logic [63:0] RECIP64 = (64'd1 << (40 + TAB_BITS)) / 64'(mpef_pkg::LN2_Q30);
	localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];
	localparam logic [31:0] RECIP6 = 32'd2863311530;

	logic [30:0] exp_tab [TAB_SIZE];

	for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
		assign exp_tab[g] = mpef_pkg::exp_frac_entry(g, TAB_BITS);
	end

	logic [LINE-1:0] vld_line_q;
	logic [LINE-1:0] big_line_q;
	logic [LINE-1:0] tiny_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_line_q <= '0;
		end else begin
			vld_line_q <= {vld_line_q[LINE-2:0], arg.valid};
		end
	end

	always_ff @(posedge clk) begin
		big_line_q  <= {big_line_q[LINE-2:0], arg.big};
		tiny_line_q <= {tiny_line_q[LINE-2:0], arg.tiny};
	end

	// e1: scale by 2^(10+bits)/ln2
	logic signed [PW-1:0] y_wide, recip_wide, yr_e1;
	logic signed [24:0]   y_e1;
	assign y_wide = PW'($signed(arg.y));
	assign recip_wide = PW'({1'b0, RECIP});

	always_ff @(posedge clk) begin
		yr_e1 <= y_wide * recip_wide;
		y_e1  <= $signed(arg.y);
	end

	// e2: estimate of the quotient, back-multiplied by ln2
	logic signed [QW-1:0] q0, q0_e2;
	logic signed [XW-1:0] ln2_wide, p0_e2;
	logic signed [24:0]   y_e2;
	assign q0 = QW'(yr_e1 >>> 30);
	assign ln2_wide = XW'({1'b0, mpef_pkg::LN2_Q30});

	always_ff @(posedge clk) begin
		p0_e2 <= XW'(q0) * ln2_wide;
		q0_e2 <= q0;
		y_e2  <= y_e1;
	end

	// e3: estimate is off by at most one either way
	logic signed [XW-1:0] x_full, diff, p_next, p_e3;
	logic signed [QW-1:0] q_next, q_e3;
	logic signed [24:0]   y_e3;
	assign x_full = XW'(y_e2) <<< (10 + TAB_BITS);
	assign diff = x_full - p0_e2;

	always_comb begin
		q_next = q0_e2;
		p_next = p0_e2;
		if (diff < 0) begin
			q_next = q0_e2 - QW'(1);
			p_next = p0_e2 - ln2_wide;
		end else if (diff >= ln2_wide) begin
			q_next = q0_e2 + QW'(1);
			p_next = p0_e2 + ln2_wide;
		end
	end

	always_ff @(posedge clk) begin
		q_e3 <= q_next;
		p_e3 <= p_next;
		y_e3 <= y_e2;
	end

	// e4: residual and table lookup
	logic signed [XW-1:0] s_full;
	logic [29:0]          s_e4;
	logic signed [5:0]    k_e4;
	logic [30:0]          frac_e4;
	assign s_full = (XW'(y_e3) <<< 10) - (p_e3 >>> TAB_BITS);

	always_ff @(posedge clk) begin
		s_e4    <= s_full[29:0];
		k_e4    <= q_e3[QW-1:TAB_BITS];
		frac_e4 <= exp_tab[q_e3[TAB_BITS-1:0]];
	end

	// e5, e6: square and cube
	logic [59:0]       sq, cu;
	logic [29:0]       s_e5, s2_e5, s_e6, s2_e6, s3_e6;
	logic signed [5:0] k_e5, k_e6;
	logic [30:0]       frac_e5, frac_e6;
	assign sq = 60'(s_e4) * 60'(s_e4);
	assign cu = 60'(s2_e5) * 60'(s_e5);

	always_ff @(posedge clk) begin
		s2_e5   <= sq[59:30];
		s_e5    <= s_e4;
		k_e5    <= k_e4;
		frac_e5 <= frac_e4;
		s3_e6   <= cu[59:30];
		s2_e6   <= s2_e5;
		s_e6    <= s_e5;
		k_e6    <= k_e5;
		frac_e6 <= frac_e5;
	end

	// e7: cube over six by reciprocal
	logic [61:0]       t6;
	logic [27:0]       q6_e7;
	logic [29:0]       s_e7, s2_e7, s3_e7;
	logic signed [5:0] k_e7;
	logic [30:0]       frac_e7;
	assign t6 = 62'(s3_e6) * 62'(RECIP6);

	always_ff @(posedge clk) begin
		q6_e7   <= t6[61:34];
		s3_e7   <= s3_e6;
		s2_e7   <= s2_e6;
		s_e7    <= s_e6;
		k_e7    <= k_e6;
		frac_e7 <= frac_e6;
	end

	// e8: quotient correction and polynomial sum
	logic [30:0]       r6, q6c, p_e8, frac_e8;
	logic signed [5:0] k_e8;
	assign r6 = 31'(s3_e7) - 31'(q6_e7) * 31'd6;
	assign q6c = 31'(q6_e7) + ((r6 >= 31'd6) ? 31'd1 : 31'd0);

	always_ff @(posedge clk) begin
		p_e8    <= mpef_pkg::Q30_ONE + 31'(s_e7) + 31'(s2_e7 >> 1) + q6c;
		frac_e8 <= frac_e7;
		k_e8    <= k_e7;
	end

	// e9: mantissa product
	logic [61:0]       mm_e9;
	logic signed [5:0] k_e9;

	always_ff @(posedge clk) begin
		mm_e9 <= 62'(frac_e8) * 62'(p_e8);
		k_e9  <= k_e8;
	end

	// e10: scale by 2^k with rounding, saturate
	logic [31:0] m;
	logic [5:0]  sh;
	logic [35:0] w, rnd;
	mpef_pkg::exp_res_t res_n, res_q;
	assign m = mm_e9[61:30];
	assign sh = 6'(6'sd10 - k_e9);
	assign w = (36'(m) << 1) + (36'd1 << sh);
	assign rnd = w >> 6'(sh + 6'd1);

	// a flushed argument carries a meaningless k, so it goes first
	always_comb begin
		res_n.valid = vld_line_q[LINE-1];
		res_n.ovf = 1'b0;
		res_n.e = rnd[30:0];
		if (tiny_line_q[LINE-1]) begin
			res_n.e = '0;
		end else if (big_line_q[LINE-1] || k_e9 > 6'sd10 || rnd > 36'h07FFFFFFF) begin
			res_n.ovf = 1'b1;
			res_n.e = 31'h7FFFFFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_n;
		end
	end

	assign res = res_q;

endmodule

FILE: dv/morse_pair_energy_force_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse_pair_energy_force_chk
// Watches the pair, register and result channels of the Morse pair block,
// works out the energy, force and overflow of every accepted pair and
// compares them in order with the results the block returns.
// ----------------------------------------------------------------------------
module morse_pair_energy_force_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [30:0]        pair_distance,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               done,
	input  logic signed [31:0] pair_energy,
	input  logic signed [31:0] pair_force,
	input  logic               overflow,
	output int                 fails,
	output int                 pending,
	output int                 seen,
	output int                 ovf_seen
);

	localparam int TAB_BITS = 8;
	localparam longint unsigned LN2 = 64'd744261118;
	localparam longint unsigned CAP = 64'd1 << 50;
	localparam longint LIM = longint'(16) << 20;
	localparam longint ONE_Q20 = longint'(1) << 20;

	typedef struct {
		logic signed [31:0] energy;
		logic signed [31:0] force_v;
		logic               ovf;
	} pair_res_t;

	pair_res_t expected_pairs[$];
	longint unsigned frac_tab[1 << TAB_BITS];
	longint depth, width, r0, eshift, fshift, cutoff;

	initial begin
		longint unsigned z, term, sum;
		for (int j = 0; j < (1 << TAB_BITS); j++) begin
			z = (longint'(j) * LN2) >> TAB_BITS;
			term = 64'd1 << 30;
			sum = term;
			for (int n = 1; n <= 24; n++) begin
				term = ((term * z) >> 30) / longint'(n);
				sum += term;
			end
			frac_tab[j] = sum & 64'hFFFF_FFFF;
		end
	end

	function automatic longint mul_round(input longint a, input longint b);
		bit neg;
		longint unsigned ua, ub, ah, al, mag;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		ah = ua >> 20;
		al = ua & 64'hFFFFF;
		if (ah != 0 && ub > CAP / ah) begin
			mag = CAP;
		end else begin
			mag = ah * ub + ((al * ub + (64'd1 << 19)) >> 20);
			if (mag > CAP) mag = CAP;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clamp32(input longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint exp_q20(input longint y, inout bit ovf);
		longint y30, k, rem;
		longint unsigned j, s, s2, s3, p, m, e;
		if (y >= LIM) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (y <= -LIM) return 0;
		y30 = y * 1024;
		k = y30 / longint'(LN2);
		if (y30 % longint'(LN2) < 0) k--;
		rem = y30 - k * longint'(LN2);
		j = ((longint'(rem) << TAB_BITS) / LN2) & ((1 << TAB_BITS) - 1);
		s = rem - ((j * LN2) >> TAB_BITS);
		s2 = (s * s) >> 30;
		s3 = (s2 * s) >> 30;
		p = (64'd1 << 30) + s + s2 / 2 + s3 / 6;
		m = (frac_tab[j] * p) >> 30;
		if (k >= 10) e = m << int'(k - 10);
		else e = (m + (64'd1 << int'(9 - k))) >> int'(10 - k);
		if (e > 64'd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		return longint'(e);
	endfunction

	function automatic pair_res_t morse_pair(input longint r);
		pair_res_t res;
		bit ovf;
		longint y, e, om, en, fo;
		ovf = 1'b0;
		y = -mul_round(width, r - r0);
		e = exp_q20(y, ovf);
		om = ONE_Q20 - e;
		en = mul_round(depth, mul_round(om, om)) - eshift - mul_round(fshift, cutoff - r);
		en = clamp32(en, ovf);
		fo = -2 * mul_round(mul_round(depth, width), mul_round(e, om)) - fshift;
		fo = clamp32(fo, ovf);
		res.energy = en[31:0];
		res.force_v = fo[31:0];
		res.ovf = ovf;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_res_t want;
		if (!arst_n) begin
			depth = 0; width = 0; r0 = 0; eshift = 0; fshift = 0; cutoff = 0;
			expected_pairs.delete();
			fails = 0; pending = 0; seen = 0; ovf_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mpef_pkg::CFG_DEPTH:  depth = longint'(cfg_data[30:0]);
					mpef_pkg::CFG_WIDTH:  width = longint'(cfg_data[30:0]);
					mpef_pkg::CFG_R0:     r0 = longint'(cfg_data[30:0]);
					mpef_pkg::CFG_ESHIFT: eshift = longint'(signed'(cfg_data));
					mpef_pkg::CFG_FSHIFT: fshift = longint'(signed'(cfg_data));
					mpef_pkg::CFG_CUTOFF: cutoff = longint'(cfg_data[30:0]);
					default: ;
				endcase
			end
			if (start && !busy) expected_pairs.push_back(morse_pair(longint'(pair_distance)));
			if (done) begin
				if (expected_pairs.size() == 0) begin
					fails++;
					$display("%0t: result beat with nothing expected: energy %h force %h ovf %b",
						$time, pair_energy, pair_force, overflow);
				end else begin
					want = expected_pairs.pop_front();
					seen++;
					if (overflow) ovf_seen++;
					if (pair_energy !== want.energy) begin
						fails++;
						$display("%0t: pair_energy expected %h actual %h", $time,
							want.energy, pair_energy);
					end
					if (pair_force !== want.force_v) begin
						fails++;
						$display("%0t: pair_force expected %h actual %h", $time,
							want.force_v, pair_force);
					end
					if (overflow !== want.ovf) begin
						fails++;
						$display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow);
					end
				end
			end
			pending = expected_pairs.size();
		end
	end

endmodule

FILE: dv/morse_pair_energy_force_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse_pair_energy_force_tb
// Drives pair distances and register settings into the Morse pair block
// with random gaps; the checker beside it predicts and compares results.
// ----------------------------------------------------------------------------
module morse_pair_energy_force_tb;

	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 9;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [30:0]        pair_distance;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               done;
	logic signed [31:0] pair_energy;
	logic signed [31:0] pair_force;
	logic               overflow;
	int                 fails, pending, seen, ovf_seen;
	int                 cycles;
	int                 sent;
	bit                 no_gaps;
	logic [30:0]        cur_r0;

	morse_pair_energy_force dut (.*);

	morse_pair_energy_force_chk chk (.*);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(input mpef_pkg::cfg_index_t idx, input logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// registers change only once the pipeline has emptied
	task automatic drain();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_pair(input logic [30:0] r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		pair_distance = r;
		do @(posedge clk); while (busy);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [30:0] pick_distance();
		longint v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = longint'(cur_r0) + longint'($urandom_range(0, 16 << 20))
				- longint'(8 << 20);
			5: v = longint'(cur_r0) + longint'($urandom_range(0, 1 << 16)) - longint'(1 << 15);
			6, 7: v = longint'($urandom() & 32'h7FFF_FFFF);
			8: v = $urandom_range(0, 1) ? 0 : 31'h7FFF_FFFF;
			default: v = cur_r0;
		endcase
		if (v < 0) v = 0;
		if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
		return v[30:0];
	endfunction

	task automatic set_phase(input int ph);
		logic [31:0] d, a, r, ec, fc, rc;
		case (ph)
			0: begin d = 1 << 20; a = 3 << 19; r = 1 << 20; ec = 32'h0000_4000;
				fc = 32'hFFFF_C000; rc = 3 << 20; end
			1: begin d = 32'h7FFF_FFFF; a = 32'h7FFF_FFFF; r = 32'h7FFF_FFFF;
				ec = 32'h7FFF_FFFF; fc = 32'h7FFF_FFFF; rc = 32'h7FFF_FFFF; end
			2: begin d = 0; a = 0; r = 0; ec = 32'h8000_0000; fc = 32'h8000_0000; rc = 0; end
			3: begin d = 32'hFFFF_FFFF; a = 1 << 20; r = 32'h8000_0000 | (2 << 20);
				ec = 0; fc = 0; rc = 32'hFFFF_FFFF; end
			4: begin d = 5 << 18; a = 4 << 20; r = 3 << 19; ec = 32'hFFF0_0000;
				fc = 32'h0002_0000; rc = 5 << 20; end
			default: begin d = $urandom_range(0, 64 << 20); a = $urandom_range(0, 8 << 20);
				r = $urandom_range(0, 16 << 20); ec = $urandom(); fc = $urandom();
				rc = $urandom_range(0, 32 << 20); end
		endcase
		write_reg(mpef_pkg::CFG_DEPTH, d);
		write_reg(mpef_pkg::CFG_WIDTH, a);
		write_reg(mpef_pkg::CFG_R0, r);
		write_reg(mpef_pkg::CFG_ESHIFT, ec);
		write_reg(mpef_pkg::CFG_FSHIFT, fc);
		write_reg(mpef_pkg::CFG_CUTOFF, rc);
		// indexes past the last register are dropped by the block
		write_reg(mpef_pkg::cfg_index_t'(3'd6), $urandom());
		write_reg(mpef_pkg::cfg_index_t'(3'd7), $urandom());
		cur_r0 = r[30:0];
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		pair_distance = '0;
		cfg_valid = 1'b0;
		cfg_index = mpef_pkg::CFG_DEPTH;
		cfg_data = '0;
		sent = 0;
		no_gaps = 1'b0;
		cur_r0 = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values: everything zero
		send_pair(0);
		send_pair(31'h7FFF_FFFF);
		drain();

		// directed: extremes of distance and exp flushing to zero
		set_phase(0);
		no_gaps = 1'b1;
		send_pair(0);
		send_pair(31'h7FFF_FFFF);
		send_pair(1 << 20);
		send_pair(31'h5555_5555);
		send_pair(31'h2AAA_AAAA);
		send_pair(20 << 20);
		send_pair(1 << 19);
		no_gaps = 1'b0;
		drain();
		set_phase(4);
		send_pair(0);
		send_pair(5 << 18);
		send_pair(3 << 19);
		send_pair(10 << 20);
		send_pair(31'h7FFF_FFFF);
		send_pair(1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_phase(ph);
			for (int i = 0; i < 120; i++) begin
				if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
				if (ph == 3 && i == 60) begin
					start = 1'b0;
					while (pending != 0) @(negedge clk);
				end
				send_pair(pick_distance());
			end
			drain();
		end

		$display("%0d pairs sent over %0d register settings, %0d results checked, %0d overflowed",
			sent, PHASES + 2, seen, ovf_seen);
		$display("extremes of distance and registers, exp saturation and underflow exercised");
		if (fails == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
